// ===== sv/toroidal_neighbour_count_assert.svh =====
// ============================================================================
// toroidal_neighbour_count_assert.svh: assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ============================================================================
`ifndef TOROIDAL_NEIGHBOUR_COUNT_ASSERT_SVH
`define TOROIDAL_NEIGHBOUR_COUNT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TNC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("toroidal_neighbour_count: assertion failed");

// next-cycle implication
`define TNC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("toroidal_neighbour_count: assertion failed");

`else

`define TNC_ASSERT_IMPL(name, ante, cons)
`define TNC_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== sv/tnc_pkg.sv =====
// ============================================================================
// tnc_pkg: shared constants for the toroidal neighbour counter
// Field widths, function codes, register indexes and default sizes.
// ============================================================================
package tnc_pkg;

  // field widths
  localparam int FUNC_W      = 2;
  localparam int POS_W       = 8;
  localparam int SLOT_W      = 5;
  localparam int OFS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int DIM_REG_W   = 9;
  localparam int SIZE_REG_W  = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // sizes
  localparam int DEF_MAX_DIM   = 256;
  localparam int DEF_MAX_NEIGH = 24;
  localparam int MIN_DIM       = 8;
  localparam int RST_DIM       = 256;
  localparam int RST_NEIGH     = 8;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE_CELL   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_OFFSET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT        = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGH_SIZE  = 2'd2;

endpackage

// ===== sv/toroidal_neighbour_count.sv =====
// ============================================================================
// toroidal_neighbour_count: wrapping neighbour counter over a one-bit grid
// Cell and offset writes are accepted only in idle. A count reads the grid once
// per offset (n = neighbourhood size) through offset read, wrap and grid read
// stages; inputs stall until the count result is posted.
// Reset starts a clearing pass that zeroes every grid cell before idle.
// ============================================================================
`include "toroidal_neighbour_count_assert.svh"

module toroidal_neighbour_count #(
  parameter int MAX_DIM   = tnc_pkg::DEF_MAX_DIM,
  parameter int MAX_NEIGH = tnc_pkg::DEF_MAX_NEIGH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transactions
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tnc_pkg::FUNC_W-1:0]      in_func,
  input  logic [tnc_pkg::POS_W-1:0]       in_pos_x,
  input  logic [tnc_pkg::POS_W-1:0]       in_pos_y,
  input  logic                            in_alive,
  input  logic [tnc_pkg::SLOT_W-1:0]      in_entry_index,
  input  logic signed [tnc_pkg::OFS_W-1:0] in_offset_x,
  input  logic signed [tnc_pkg::OFS_W-1:0] in_offset_y,
  // result transactions
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tnc_pkg::COUNT_W-1:0]     out_live_count,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tnc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tnc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW  = $clog2(MAX_DIM);
  localparam int PW  = (AW > tnc_pkg::POS_W) ? AW : tnc_pkg::POS_W;
  localparam int CW  = PW + 3;
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int GAW = 2 * AW;
  localparam int IW  = $clog2(MAX_NEIGH);
  localparam int NW  = $clog2(MAX_NEIGH + 1);
  localparam int EW  = 2 * tnc_pkg::OFS_W;
  localparam int DIM_RST   = (tnc_pkg::RST_DIM > MAX_DIM) ? MAX_DIM : tnc_pkg::RST_DIM;
  localparam int NEIGH_RST = (tnc_pkg::RST_NEIGH > MAX_NEIGH) ? MAX_NEIGH : tnc_pkg::RST_NEIGH;
  localparam int DIM_REG_W_L = tnc_pkg::DIM_REG_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_COUNT} state_t;

  state_t              state_r;
  logic [GAW-1:0]      clr_addr_r;
  logic [DW-1:0]       w_r, h_r;
  logic [NW-1:0]       n_r;
  logic [NW-1:0]       idx_r;
  logic [tnc_pkg::COUNT_W-1:0] cnt_r;
  logic                s1_v_r, s2_v_r, s3_v_r;
  logic                out_valid_r;
  logic [tnc_pkg::COUNT_W-1:0] out_live_count_r;

  logic [tnc_pkg::POS_W-1:0] px_r, py_r;
  logic [EW-1:0]       ofs_q_r;
  logic [GAW-1:0]      gaddr_r;
  logic                grid_q_r;

  logic                grid_mem [2**GAW];
  logic [EW-1:0]       ofs_mem  [MAX_NEIGH];

  logic                in_acc;
  logic                issue;
  logic                count_done;
  logic                g_we;
  logic [GAW-1:0]      g_waddr;
  logic                g_wdata;
  logic                cell_in_range;
  logic                slot_in_range;
  logic [DIM_REG_W_L-1:0] cfg_dim;
  logic [DW-1:0]       cfg_dim_c;
  logic [NW-1:0]       cfg_size_c;
  logic [CW:0]         wx, wy;

  // wrap one coordinate once around dim; MSB flags a coordinate inside the grid
  function automatic logic [CW:0] wrap_coord(input logic [tnc_pkg::POS_W-1:0] p,
                                             input logic [tnc_pkg::OFS_W-1:0] d,
                                             input logic [DW-1:0]             dim);
    logic signed [CW-1:0] c0, c1, c2, dim_s;
    logic                 ok;
    dim_s = signed'(CW'(dim));
    c0 = signed'(CW'(p)) + CW'(signed'(d));
    c1 = (c0 < 0) ? c0 + dim_s : c0;
    c2 = (c1 >= dim_s) ? c1 - dim_s : c1;
    ok = (c2 >= 0) && (c2 < dim_s);
    return {ok, c2};
  endfunction

  // handshakes
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_live_count = out_live_count_r;

  // configuration values, saturated into range at write time
  assign cfg_dim = cfg_data[DIM_REG_W_L-1:0];
  always_comb begin
    if (cfg_dim < DIM_REG_W_L'(tnc_pkg::MIN_DIM)) begin
      cfg_dim_c = DW'(tnc_pkg::MIN_DIM);
    end else if (32'(cfg_dim) > 32'(MAX_DIM)) begin
      cfg_dim_c = DW'(MAX_DIM);
    end else begin
      cfg_dim_c = DW'(cfg_dim);
    end
    if (32'(cfg_data[tnc_pkg::SIZE_REG_W-1:0]) > 32'(MAX_NEIGH)) begin
      cfg_size_c = NW'(MAX_NEIGH);
    end else begin
      cfg_size_c = NW'(cfg_data[tnc_pkg::SIZE_REG_W-1:0]);
    end
  end

  // range checks on write transactions
  assign cell_in_range = (32'(in_pos_x) < 32'(MAX_DIM)) && (32'(in_pos_y) < 32'(MAX_DIM));
  assign slot_in_range = 32'(in_entry_index) < 32'(MAX_NEIGH);

  // grid write port: clearing pass or cell write
  always_comb begin
    if (state_r == S_CLEAR) begin
      g_we    = 1'b1;
      g_waddr = clr_addr_r;
      g_wdata = 1'b0;
    end else begin
      g_we    = in_acc && (in_func == tnc_pkg::FUNC_WRITE_CELL) && cell_in_range;
      g_waddr = {AW'(in_pos_y), AW'(in_pos_x)};
      g_wdata = in_alive;
    end
  end

  // count sequencing
  assign issue      = (state_r == S_COUNT) && (idx_r != n_r);
  assign count_done = (state_r == S_COUNT) && !issue && !s1_v_r && !s2_v_r && !s3_v_r &&
                      (!out_valid_r || !out_stall);

  // wrap stage on the offset just read
  assign wx = wrap_coord(px_r, ofs_q_r[EW-1:tnc_pkg::OFS_W], w_r);
  assign wy = wrap_coord(py_r, ofs_q_r[tnc_pkg::OFS_W-1:0], h_r);

  // cell grid memory
  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    grid_q_r <= grid_mem[gaddr_r];
  end

  // offset table memory
  always_ff @(posedge clk) begin
    if (in_acc && (in_func == tnc_pkg::FUNC_WRITE_OFFSET) && slot_in_range) begin
      ofs_mem[IW'(in_entry_index)] <= {in_offset_x, in_offset_y};
    end
    if (issue) begin
      ofs_q_r <= ofs_mem[idx_r[IW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
    gaddr_r <= {wy[AW-1:0], wx[AW-1:0]};
  end

  // control state machine and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      w_r         <= DW'(DIM_RST);
      h_r         <= DW'(DIM_RST);
      n_r         <= NW'(NEIGH_RST);
      idx_r       <= '0;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tnc_pkg::REG_GRID_WIDTH:  w_r <= cfg_dim_c;
          tnc_pkg::REG_GRID_HEIGHT: h_r <= cfg_dim_c;
          tnc_pkg::REG_NEIGH_SIZE:  n_r <= cfg_size_c;
          default: ;
        endcase
      end

      // new result posted, or the waiting one taken downstream
      if (count_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // read pipeline
      s1_v_r <= issue;
      s2_v_r <= s1_v_r && wx[CW] && wy[CW];
      s3_v_r <= s2_v_r;
      if (s3_v_r && grid_q_r) begin
        cnt_r <= cnt_r + 1'b1;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_func == tnc_pkg::FUNC_COUNT)) begin
            state_r <= S_COUNT;
            idx_r   <= '0;
            cnt_r   <= '0;
          end
        end
        S_COUNT: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (count_done) begin
            out_live_count_r <= cnt_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  // assertions
  `TNC_ASSERT_IMPL(a_pipe_only_in_count, s1_v_r || s2_v_r || s3_v_r, state_r == S_COUNT)
  `TNC_ASSERT_IMPL(a_idx_bounded, state_r == S_COUNT, idx_r <= n_r)
  `TNC_ASSERT_IMPL(a_cnt_le_issued, state_r == S_COUNT, 32'(cnt_r) <= 32'(idx_r))
  `TNC_ASSERT_IMPL(a_no_result_in_clear, state_r == S_CLEAR, !out_valid_r)
  `TNC_ASSERT_NEXT(a_done_posts_result, count_done, out_valid_r && (state_r == S_IDLE))

endmodule
